### design/sorted_min_priority_queue_top_defines.svh
// assertion macros for the sorted min priority queue checker
`ifndef SORTED_MIN_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_MIN_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SMPQ_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smpq assertion failed");

// next-cycle implication, disabled in reset
`define SMPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smpq assertion failed");

`endif

### design/smpq_pkg.sv
// shared types and constants for the sorted min priority queue
`timescale 1ns / 1ps

package smpq_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int LIST_MAX    = (MAX_RESULTS < CAPACITY) ? MAX_RESULTS : CAPACITY;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int OCC_W       = 5;
  localparam int VAL_W       = 32;

  localparam int CMD_DEPTH   = 2;
  localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
  localparam int OUT_DEPTH   = 2;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  localparam logic [2:0] ACT_PUSH  = 3'd0;
  localparam logic [2:0] ACT_POP   = 3'd1;
  localparam logic [2:0] ACT_TOP   = 3'd2;
  localparam logic [2:0] ACT_DROP  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH, OP_POP, OP_TOP, OP_DROP, OP_CLEAR, OP_NOP
  } op_t;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [1:0]              status;
    logic [OCC_W-1:0]        occupancy;
    logic                    last;
  } result_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                    insert;
    logic                    remove;
    logic                    clear;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

### design/smpq_front.sv
// front end: accepts requests, decodes the action and queues commands
`timescale 1ns / 1ps

module smpq_front import smpq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  request_t request,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  cmd_t                 slots [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  cmd_t                 decoded;
  logic                 wr_en;
  logic                 rd_en;

  always_comb begin
    decoded.value = request.value;
    unique case (request.action)
      ACT_PUSH:  decoded.op = OP_PUSH;
      ACT_POP:   decoded.op = OP_POP;
      ACT_TOP:   decoded.op = OP_TOP;
      ACT_DROP:  decoded.op = OP_DROP;
      ACT_CLEAR: decoded.op = OP_CLEAR;
      default:   decoded.op = OP_NOP;
    endcase
  end

  assign full      = (count == CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rd_ptr];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + CMD_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + CMD_PTR_W'(1);
      end
      count <= count + CMD_CNT_W'(wr_en) - CMD_CNT_W'(rd_en);
    end
  end

endmodule

### design/smpq_cells.sv
// shift-cell array holding the entries in ascending order
`timescale 1ns / 1ps

module smpq_cells import smpq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cell_ctrl_t              ctrl,
  input  logic [IDX_W-1:0]        rd_idx,
  output logic signed [VAL_W-1:0] rd_data,
  output logic [CNT_W-1:0]        count
);

  logic signed [VAL_W-1:0] entries      [CAPACITY];
  logic signed [VAL_W-1:0] entries_next [CAPACITY];
  logic [CAPACITY-1:0]     ins_here;
  logic [CAPACITY-1:0]     shift_up;

  // insert point: first held entry greater than the value, or the free slot
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ins_here[i] = ((CNT_W'(i) < count) && (ctrl.value < entries[i])) ||
                    (CNT_W'(i) == count);
    end
    shift_up[0] = 1'b0;
    for (int i = 1; i < CAPACITY; i++) begin
      shift_up[i] = ins_here[i] && ins_here[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_next[i] = entries[i];
    end
    if (ctrl.insert) begin
      entries_next[0] = ins_here[0] ? ctrl.value : entries[0];
      for (int i = 1; i < CAPACITY; i++) begin
        if (shift_up[i]) begin
          entries_next[i] = entries[i-1];
        end else if (ins_here[i]) begin
          entries_next[i] = ctrl.value;
        end
      end
    end else if (ctrl.remove) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        entries_next[i] = entries[i+1];
      end
    end
  end

  assign rd_data = entries[rd_idx];

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries[i] <= entries_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (ctrl.insert) begin
      count <= count + CNT_W'(1);
    end else if (ctrl.remove) begin
      count <= count - CNT_W'(1);
    end
  end

endmodule

### design/smpq_back.sv
// back end: runs commands on the cell array and queues the results
`timescale 1ns / 1ps

module smpq_back import smpq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  input  cmd_t                    cmd,
  output logic                    cmd_pop,
  output cell_ctrl_t              ctrl,
  output logic [IDX_W-1:0]        rd_idx,
  input  logic signed [VAL_W-1:0] rd_data,
  input  logic [CNT_W-1:0]        count,
  output logic                    empty,
  input  logic                    pop,
  output result_t                 result
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     idx_next;

  result_t              slots [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_CNT_W-1:0] ocount;

  logic                 out_pop;
  logic                 out_room;
  logic                 res_push;
  result_t              res;
  logic [CNT_W-1:0]     list_len;
  logic                 is_empty;

  assign out_pop  = pop && !empty;
  assign out_room = (ocount != OUT_CNT_W'(OUT_DEPTH)) || out_pop;
  assign list_len = (count < CNT_W'(LIST_MAX)) ? count : CNT_W'(LIST_MAX);
  assign is_empty = (count == '0);
  assign rd_idx   = (state == S_LIST) ? idx : '0;

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    cmd_pop          = 1'b0;
    res_push         = 1'b0;
    ctrl.insert      = 1'b0;
    ctrl.remove      = 1'b0;
    ctrl.clear       = 1'b0;
    ctrl.value       = cmd.value;
    res.result_value = '0;
    res.status       = ST_OK;
    res.occupancy    = OCC_W'(count);
    res.last         = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && out_room) begin
          cmd_pop  = 1'b1;
          res_push = 1'b1;
          case (cmd.op)
            OP_PUSH: begin
              if (count == CNT_W'(CAPACITY)) begin
                res.status = ST_FULL;
              end else begin
                ctrl.insert   = 1'b1;
                res.occupancy = OCC_W'(count + CNT_W'(1));
              end
            end
            OP_POP: begin
              if (is_empty) begin
                res.status = ST_EMPTY;
              end else begin
                ctrl.remove   = 1'b1;
                res.occupancy = OCC_W'(count - CNT_W'(1));
              end
            end
            OP_TOP, OP_DROP: begin
              if (is_empty) begin
                res.status = ST_EMPTY;
              end else begin
                res.result_value = rd_data;
                if (cmd.op == OP_DROP && list_len != CNT_W'(1)) begin
                  res.last   = 1'b0;
                  idx_next   = IDX_W'(1);
                  state_next = S_LIST;
                end
              end
            end
            OP_CLEAR: begin
              ctrl.clear    = 1'b1;
              res.occupancy = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_LIST: begin
        if (out_room) begin
          res_push         = 1'b1;
          res.result_value = rd_data;
          res.last         = (CNT_W'(idx) + CNT_W'(1) == list_len);
          idx_next         = idx + IDX_W'(1);
          if (res.last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // result queue
  assign empty  = (ocount == '0);
  assign result = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_push) begin
      slots[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      ocount <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      end
      if (out_pop) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      ocount <= ocount + OUT_CNT_W'(res_push) - OUT_CNT_W'(out_pop);
    end
  end

endmodule

### design/sorted_min_priority_queue_top.sv
// top level of the sorted min priority queue
// Usage: requests enter on a queue-style port: request carries action and value, and a
// request is taken at a clock edge with push high and full low. Results leave the same
// way: result shows the oldest waiting result while empty is low, and it is taken at a
// clock edge with pop high and empty low.
// Every request gives one result with last set, except drop on a non-empty queue, which
// gives one result per held entry, smallest first, last set on the final one.
// A taken request is written into the command queue; the execution stage pops it from
// there when the result queue has room and writes its result into the result queue,
// which drives the result port. Push, pop, top, clear and unknown actions are each a
// single step of the execution stage, which then takes the next command; drop holds the
// execution stage until each listed entry has been written to the result queue.
// Reset (rst, synchronous) empties both queues and sets the entry count to zero.
// When the receiver stalls, the two-entry result queue fills, the execution stage holds,
// the two-entry command queue fills and full rises; nothing is lost.
`timescale 1ns / 1ps

module sorted_min_priority_queue_top import smpq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  request_t request,
  output logic     empty,
  input  logic     pop,
  output result_t  result
);

  logic                    cmd_valid;
  cmd_t                    cmd;
  logic                    cmd_pop;
  cell_ctrl_t              ctrl;
  logic [IDX_W-1:0]        rd_idx;
  logic signed [VAL_W-1:0] rd_data;
  logic [CNT_W-1:0]        count;

  smpq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  smpq_cells u_cells (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .count   (count)
  );

  smpq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .ctrl      (ctrl),
    .rd_idx    (rd_idx),
    .rd_data   (rd_data),
    .count     (count),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

### design/smpq_checker.sv
// port-level checker for the sorted min priority queue, bound to the top level
`timescale 1ns / 1ps
`include "sorted_min_priority_queue_top_defines.svh"

module smpq_checker import smpq_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  // full status only when the queue holds its capacity
  `SMPQ_ASSERT(a_full_occ, !empty && result.status == ST_FULL, result.occupancy == OCC_W'(CAPACITY) && result.last)

  // empty status carries zero data and zero occupancy
  `SMPQ_ASSERT(a_empty_res, !empty && result.status == ST_EMPTY, result.result_value == '0 && result.occupancy == '0 && result.last)

  // only a listing run has non-final results, and they are all ok
  `SMPQ_ASSERT(a_run_ok, !empty && !result.last, result.status == ST_OK && result.occupancy != '0)

  // a waiting result holds until taken
  `SMPQ_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result))

endmodule

bind sorted_min_priority_queue_top smpq_checker u_smpq_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

### tb/tb_top.sv
// self-checking testbench for the sorted min priority queue
`timescale 1ns / 1ps

module tb_top import smpq_pkg::*; ();

  localparam logic [2:0] ACT_RSVD_A = 3'd5;
  localparam logic [2:0] ACT_RSVD_B = 3'd6;
  localparam logic [2:0] ACT_RSVD_C = 3'd7;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;
  localparam int RANDOM_REQUESTS = 215;
  localparam int PHASE_LEN = 25;
  localparam int STALL_MAX = 10;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [2:0]              action;
    logic signed [VAL_W-1:0] value;
    int                      reps;
    bit                      typed;
    result_t                 want;
  } stim_row_t;

  localparam int N_ROWS = 21;

  logic     clk;
  logic     rst;
  logic     push;
  logic     full;
  request_t request;
  logic     empty;
  logic     pop;
  result_t  result;

  logic signed [VAL_W-1:0] shadow_entries [CAPACITY];
  int                      shadow_count;
  result_t                 awaited_results [$];
  int                      mismatch_count;
  int                      idle_cycles;
  bit                      send_steady;
  bit                      take_steady;

  stim_row_t directed_rows [N_ROWS] = '{
    '{ACT_TOP,    0,            1,  1'b1, '{0, ST_EMPTY, 5'd0, 1'b1}},
    '{ACT_POP,    0,            1,  1'b1, '{0, ST_EMPTY, 5'd0, 1'b1}},
    '{ACT_DROP,   0,            1,  1'b1, '{0, ST_EMPTY, 5'd0, 1'b1}},
    '{ACT_RSVD_A, -1,           1,  1'b1, '{0, ST_OK, 5'd0, 1'b1}},
    '{ACT_PUSH,   VAL_MAX,      1,  1'b1, '{0, ST_OK, 5'd1, 1'b1}},
    '{ACT_PUSH,   VAL_MIN,      1,  1'b1, '{0, ST_OK, 5'd2, 1'b1}},
    '{ACT_TOP,    0,            1,  1'b1, '{VAL_MIN, ST_OK, 5'd2, 1'b1}},
    '{ACT_PUSH,   0,            1,  1'b0, '{0, ST_OK, 5'd0, 1'b0}},
    '{ACT_PUSH,   -1,           1,  1'b0, '{0, ST_OK, 5'd0, 1'b0}},
    '{ACT_PUSH,   5,            2,  1'b0, '{0, ST_OK, 5'd0, 1'b0}},
    '{ACT_DROP,   0,            1,  1'b0, '{0, ST_OK, 5'd0, 1'b0}},
    '{ACT_RSVD_B, 32'h5a5a5a5a, 1,  1'b0, '{0, ST_OK, 5'd0, 1'b0}},
    '{ACT_RSVD_C, 32'ha5a5a5a5, 1,  1'b0, '{0, ST_OK, 5'd0, 1'b0}},
    '{ACT_POP,    0,            1,  1'b1, '{0, ST_OK, 5'd5, 1'b1}},
    '{ACT_TOP,    0,            1,  1'b0, '{0, ST_OK, 5'd0, 1'b0}},
    '{ACT_CLEAR,  0,            1,  1'b1, '{0, ST_OK, 5'd0, 1'b1}},
    '{ACT_PUSH,   32'h12345678, 15, 1'b0, '{0, ST_OK, 5'd0, 1'b0}},
    '{ACT_PUSH,   VAL_MIN,      1,  1'b1, '{0, ST_OK, 5'd16, 1'b1}},
    '{ACT_PUSH,   VAL_MAX,      1,  1'b1, '{0, ST_FULL, 5'd16, 1'b1}},
    '{ACT_DROP,   0,            1,  1'b0, '{0, ST_OK, 5'd0, 1'b0}},
    '{ACT_CLEAR,  0,            1,  1'b1, '{0, ST_OK, 5'd0, 1'b1}}
  };

  sorted_min_priority_queue_top dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  always #6 clk = ~clk;

  function automatic result_t make_result(logic signed [VAL_W-1:0] v, logic [1:0] st,
                                          logic lst);
    result_t r;
    r.result_value = v;
    r.status = st;
    r.occupancy = shadow_count[OCC_W-1:0];
    r.last = lst;
    return r;
  endfunction

  function automatic void add_awaited(result_t r);
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  // updates the shadow queue and appends the results the request should give
  function automatic void apply_action(request_t req);
    int pos;
    int n;
    case (req.action)
      ACT_PUSH: begin
        if (shadow_count >= CAPACITY) begin
          add_awaited(make_result(0, ST_FULL, 1'b1));
        end else begin
          pos = 0;
          while (pos < shadow_count && !(req.value < shadow_entries[pos])) pos++;
          for (int i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[pos] = req.value;
          shadow_count++;
          add_awaited(make_result(0, ST_OK, 1'b1));
        end
      end
      ACT_POP: begin
        if (shadow_count == 0) begin
          add_awaited(make_result(0, ST_EMPTY, 1'b1));
        end else begin
          for (int i = 1; i < shadow_count; i++) shadow_entries[i-1] = shadow_entries[i];
          shadow_count--;
          add_awaited(make_result(0, ST_OK, 1'b1));
        end
      end
      ACT_TOP: begin
        if (shadow_count == 0) begin
          add_awaited(make_result(0, ST_EMPTY, 1'b1));
        end else begin
          add_awaited(make_result(shadow_entries[0], ST_OK, 1'b1));
        end
      end
      ACT_DROP: begin
        if (shadow_count == 0) begin
          add_awaited(make_result(0, ST_EMPTY, 1'b1));
        end else begin
          n = (shadow_count < MAX_RESULTS) ? shadow_count : MAX_RESULTS;
          for (int i = 0; i < n; i++)
            add_awaited(make_result(shadow_entries[i], ST_OK, i + 1 == n));
        end
      end
      ACT_CLEAR: begin
        shadow_count = 0;
        add_awaited(make_result(0, ST_OK, 1'b1));
      end
      default: begin
        add_awaited(make_result(0, ST_OK, 1'b1));
      end
    endcase
  endfunction

  task automatic send_request(request_t req, bit typed, result_t want);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    request <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    apply_action(req);
    if (typed) begin
      awaited_results[awaited_results.size() - 1] = want;
    end
    @(negedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] draw_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return $signed($urandom_range(0, 16)) - 8;
    if (pick < 45) return VAL_MAX;
    if (pick < 50) return VAL_MIN;
    return $urandom;
  endfunction

  function automatic logic [2:0] draw_action(int push_pct);
    int pick;
    if ($urandom_range(0, 99) < push_pct) return ACT_PUSH;
    pick = $urandom_range(0, 99);
    if (pick < 50) return ACT_POP;
    if (pick < 68) return ACT_TOP;
    if (pick < 88) return ACT_DROP;
    if (pick < 92) return ACT_CLEAR;
    return 3'($urandom_range(ACT_RSVD_A, ACT_RSVD_C));
  endfunction

  initial begin
    request_t req;
    int push_pct;
    clk = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    request = '0;
    shadow_count = 0;
    mismatch_count = 0;
    send_steady = 1'b0;
    take_steady = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        req.action = directed_rows[r].action;
        req.value = directed_rows[r].value;
        send_request(req, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    push_pct = 50;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % PHASE_LEN == 0) begin
        push_pct = $urandom_range(20, 85);
        send_steady = ($urandom_range(0, 3) == 0);
        take_steady = ($urandom_range(0, 3) == 0);
      end
      req.action = draw_action(push_pct);
      req.value = draw_value();
      send_request(req, 1'b0, '0);
    end
    push <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    int stall;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = take_steady ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: value %0d status %0d occupancy %0d last %0b",
               result.result_value, result.status, result.occupancy, result.last);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (result.result_value !== want.result_value) begin
          $error("result_value: expected %0d, got %0d", want.result_value,
                 result.result_value);
          mismatch_count++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          mismatch_count++;
        end
        if (result.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, result.occupancy);
          mismatch_count++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, result.last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
